[rtl/hbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_pkg: shared types, constants and functions
// Letter widths, register indexes, the cell-to-cell beat and modulo-26 helpers.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int NumCells = 4;   // cells in the chain, one per block letter
  localparam int KeyRows  = 4;
  localparam int LetterW  = 5;
  localparam int SumW     = 10;  // largest cell sum is 25 + 26 * 25 = 675
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [1:0]         row_t;
  typedef logic [2:0]         size_t;

  localparam logic [CfgIdxW-1:0] RegBlockSize = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyRow0   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyRow1   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyRow2   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyRow3   = 3'd4;

  localparam letter_t      PadValue   = 5'd26;
  localparam logic [6:0]   AsciiBase  = 7'd64;  // 'A' minus one
  localparam logic [7:0]   UpperFirst = 8'd65;  // 'A'
  localparam logic [7:0]   UpperLast  = 8'd90;  // 'Z'
  localparam logic [7:0]   LowerFirst = 8'd97;  // 'a'
  localparam logic [7:0]   LowerLast  = 8'd122; // 'z'

  // Beat handed from one cell to the next.
  typedef struct packed {
    logic    valid;
    row_t    row;
    letter_t psum;
    logic    last;
  } cell_beat_t;

  // Remainder by 26 for values below 1024, via a scaled reciprocal.
  function automatic letter_t mod26(input logic [SumW-1:0] x);
    logic [21:0]     prod;
    logic [5:0]      quot;
    logic [SumW-1:0] rem;
    prod = 22'(x) * 22'd2521;
    quot = prod[21:16];
    rem  = x - SumW'({4'b0, quot} * 10'd26);
    return rem[LetterW-1:0];
  endfunction

  // Key letters above 25 wrap into 0..5.
  function automatic letter_t key_mod(input letter_t k);
    return (k >= 5'd26) ? letter_t'(k - 5'd26) : k;
  endfunction

endpackage

`default_nettype wire

[rtl/hbe_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_if: stream channels of the cipher block
// Text byte channel in, cipher letter channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbe_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface hbe_cipher_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_letter;
  logic       block_end;

  modport source (output valid, output cipher_letter, output block_end, input ready);
  modport sink   (input valid, input cipher_letter, input block_end, output ready);
endinterface

`default_nettype wire

[rtl/hbe_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_cell: one multiply-accumulate cell of the cipher chain
// Holds one plaintext letter and adds letter * key[row][col] mod 26 to the
// partial sum passing through while the cell is active.
// ----------------------------------------------------------------------------
module hbe_cell (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       advance,
  input  wire logic                                       active,
  input  wire logic                                       load_en,
  input  wire hbe_pkg::letter_t                           load_value,
  input  wire logic [hbe_pkg::KeyRows-1:0][hbe_pkg::LetterW-1:0] key_col,
  input  wire hbe_pkg::cell_beat_t                        beat_in,
  output hbe_pkg::cell_beat_t                             beat_out
);
  import hbe_pkg::*;

  letter_t         letter;
  letter_t         key_val;
  logic [SumW-1:0] prod;
  logic [SumW-1:0] sum;
  letter_t         psum_next;

  always_comb begin
    key_val   = key_mod(key_col[beat_in.row]);
    prod      = SumW'(letter) * SumW'(key_val);
    sum       = SumW'(beat_in.psum) + (active ? prod : '0);
    psum_next = mod26(sum);
  end

  // Letter store: written only while the chain is empty.
  always_ff @(posedge clk) begin
    if (load_en) begin
      letter <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (advance) begin
      beat_out.valid <= beat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_out.row  <= beat_in.row;
      beat_out.psum <= psum_next;
      beat_out.last <= beat_in.last;
    end
  end

endmodule

`default_nettype wire

[rtl/hill_block_encrypt_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Output: a beat that completes (or flushes) a block starts the rows, which pass
//   through the four cells into the output register; the n letters, n = 2..4,
//   follow one per cycle while the cipher side takes them. A text beat that does not
//   finish a block leaves ready high; a finishing beat holds ready low while rows walk the chain.
// Reset (rst, synchronous, active high): block size 2, key rows zero, buffer empty,
//   no beat in flight; the output register comes up empty.
// ----------------------------------------------------------------------------
// hill_block_encrypt_core: Hill cipher encryption over a byte stream
// Buffers letters 1..26 in a chain of cells, one letter per cell, then streams
// key rows through the chain; each cell adds its letter times its key column
// entry mod 26, and the chain tail emits the cipher letter.
// ----------------------------------------------------------------------------
module hill_block_encrypt_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hbe_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [hbe_pkg::CfgDataW-1:0]   cfg_data,
  hbe_text_if.sink                            text_in,
  hbe_cipher_if.source                        cipher_out
);
  import hbe_pkg::*;

  // Configuration registers
  size_t                block_size;
  logic [CfgDataW-1:0]  key_rows [KeyRows];

  // Buffer control
  size_t  count;
  logic   issuing;
  row_t   issue_row;

  // Output register
  logic       out_valid;
  logic [6:0] out_letter;
  logic       out_end;

  size_t      eff_n;
  letter_t    letter_val;
  logic       is_letter;
  logic       accept;
  size_t      count_after;
  logic       block_done;
  logic       flush;
  logic       busy;
  logic       advance;
  logic       last_row;
  logic [NumCells-1:0] chain_valid;

  cell_beat_t chain [NumCells+1];

  // Clamp block size to 2..4.
  always_comb begin
    if (block_size < 3'd2) begin
      eff_n = 3'd2;
    end else if (block_size > size_t'(NumCells)) begin
      eff_n = size_t'(NumCells);
    end else begin
      eff_n = block_size;
    end
  end

  // Classify the byte: letters map to 1..26, everything else drops.
  always_comb begin
    letter_val = '0;
    is_letter  = 1'b0;
    if (text_in.text_byte >= UpperFirst && text_in.text_byte <= UpperLast) begin
      letter_val = letter_t'(text_in.text_byte - UpperFirst + 8'd1);
      is_letter  = 1'b1;
    end else if (text_in.text_byte >= LowerFirst && text_in.text_byte <= LowerLast) begin
      letter_val = letter_t'(text_in.text_byte - LowerFirst + 8'd1);
      is_letter  = 1'b1;
    end
  end

  // Hold input while any row is still being issued or is in the chain.
  always_comb begin
    for (int j = 0; j < NumCells; j++) begin
      chain_valid[j] = chain[j+1].valid;
    end
  end

  assign busy          = issuing || (|chain_valid);
  assign text_in.ready = !busy;
  assign accept        = text_in.valid && text_in.ready;

  assign count_after = is_letter ? size_t'(count + 3'd1) : count;
  assign block_done  = is_letter && (count_after >= eff_n);
  assign flush       = text_in.end_of_text && (count_after != '0) && !block_done;

  // Whole chain steps when the output register can take the tail beat.
  assign advance  = !out_valid || cipher_out.ready;
  assign last_row = ({1'b0, issue_row} == size_t'(eff_n - 3'd1));

  // Head of the chain: key row index with a zero partial sum.
  always_comb begin
    chain[0].valid = issuing;
    chain[0].row   = issue_row;
    chain[0].psum  = '0;
    chain[0].last  = last_row;
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= 3'd2;
      for (int r = 0; r < KeyRows; r++) begin
        key_rows[r] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        RegBlockSize: block_size  <= cfg_data[2:0];
        RegKeyRow0:   key_rows[0] <= cfg_data;
        RegKeyRow1:   key_rows[1] <= cfg_data;
        RegKeyRow2:   key_rows[2] <= cfg_data;
        RegKeyRow3:   key_rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Letter count and row issue sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issuing   <= 1'b0;
      issue_row <= '0;
    end else begin
      if (accept) begin
        if (block_done || flush) begin
          count     <= '0;
          issuing   <= 1'b1;
          issue_row <= '0;
        end else begin
          count <= count_after;
        end
      end else if (issuing && advance) begin
        issue_row <= row_t'(issue_row + 2'd1);
        if (last_row) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // Cell row: cell j holds letter j and key column j of every row.
  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    logic [KeyRows-1:0][LetterW-1:0] key_col;
    logic    load_en;
    letter_t load_value;
    logic    active;
    logic    store_hit;

    for (genvar r = 0; r < KeyRows; r++) begin : g_col
      assign key_col[r] = key_rows[r][LetterW*j +: LetterW];
    end

    // Store the new letter at the fill position; pad the tail with Z on flush.
    assign store_hit  = is_letter && (count == size_t'(j));
    assign load_en    = accept && (store_hit || (flush && (size_t'(j) >= count_after)));
    assign load_value = store_hit ? letter_val : PadValue;
    assign active     = (size_t'(j) < eff_n);

    hbe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .active     (active),
      .load_en    (load_en),
      .load_value (load_value),
      .key_col    (key_col),
      .beat_in    (chain[j]),
      .beat_out   (chain[j+1])
    );
  end

  // Output register: a sum of zero is written as Z.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[NumCells].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_letter <= AsciiBase + 7'((chain[NumCells].psum == '0) ? PadValue
                                                               : chain[NumCells].psum);
      out_end    <= chain[NumCells].last;
    end
  end

  assign cipher_out.valid         = out_valid;
  assign cipher_out.cipher_letter = out_letter;
  assign cipher_out.block_end     = out_end;

endmodule

`default_nettype wire

[rtl/hbe_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbe_checker: port-level checks for the cipher block
// Watches the text and cipher channels of the top level.
// ----------------------------------------------------------------------------
module hbe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] text_byte,
  input wire logic       end_of_text,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] cipher_letter,
  input wire logic       block_end
);
  import hbe_pkg::*;

  logic is_letter;

  assign is_letter = (text_byte >= UpperFirst && text_byte <= UpperLast) ||
                     (text_byte >= LowerFirst && text_byte <= LowerLast);

  // Output comes up empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("cipher output valid right after reset");

  // Cipher letters are always upper case.
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cipher_letter >= 7'd65 && cipher_letter <= 7'd90))
    else $error("cipher letter outside A..Z");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(cipher_letter) && $stable(block_end)))
    else $error("cipher beat changed while stalled");

  // A dropped byte that does not end the text keeps the input open.
  a_drop_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !is_letter && !end_of_text) |=> in_ready)
    else $error("input closed after a dropped byte");

endmodule

bind hill_block_encrypt_core hbe_checker u_hbe_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (text_in.valid),
  .in_ready      (text_in.ready),
  .text_byte     (text_in.text_byte),
  .end_of_text   (text_in.end_of_text),
  .out_valid     (cipher_out.valid),
  .out_ready     (cipher_out.ready),
  .cipher_letter (cipher_out.cipher_letter),
  .block_end     (cipher_out.block_end)
);

`default_nettype wire

[tb/hill_cipher_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_checker: cipher stream predictor and comparator
// Follows the config port and every accepted text beat with its own Hill
// cipher model, queues the cipher letters that must come out and compares
// each accepted cipher beat, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module hill_cipher_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hbe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hbe_pkg::CfgDataW-1:0] cfg_data,
  hbe_text_if                          text_mon,
  hbe_cipher_if                        cipher_mon,
  output int                           mismatch_count,
  output int                           letters_pending
);
  import hbe_pkg::*;

  localparam int Modulus = 26;

  typedef struct packed {
    logic [6:0] cipher_letter;
    logic       block_end;
  } cipher_beat_t;

  size_t               block_size;
  logic [CfgDataW-1:0] key_row [KeyRows];
  letter_t             held [NumCells];
  int                  held_count;
  cipher_beat_t        cipher_expected_q [$];

  // Clamp the programmed size into 2..4.
  function automatic int active_size();
    int n;
    n = int'(block_size);
    if (n < 2) n = 2;
    if (n > NumCells) n = NumCells;
    if (n > KeyRows) n = KeyRows;
    return n;
  endfunction

  // Key fields above 25 wrap around.
  function automatic int key_entry(input int row, input int col);
    return int'(key_row[row][LetterW*col +: LetterW]) % Modulus;
  endfunction

  task automatic encrypt_held_letters(input int n);
    int           sum;
    cipher_beat_t beat;
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < n; j++) sum += int'(held[j]) * key_entry(i, j);
      sum = sum % Modulus;
      if (sum == 0) sum = int'(PadValue);
      beat.cipher_letter = AsciiBase + 7'(sum);
      beat.block_end     = (i == n - 1);
      cipher_expected_q  = {cipher_expected_q, beat};
    end
    held_count = 0;
  endtask

  task automatic absorb_text(input logic [7:0] text_byte, input logic end_of_text);
    int n;
    int value;
    n     = active_size();
    value = 0;
    if (text_byte >= UpperFirst && text_byte <= UpperLast)
      value = text_byte - UpperFirst + 1;
    else if (text_byte >= LowerFirst && text_byte <= LowerLast)
      value = text_byte - LowerFirst + 1;

    if (value != 0) begin
      if (held_count < NumCells) held[held_count] = letter_t'(value);
      held_count++;
      if (held_count >= n) begin
        encrypt_held_letters(n);
        return;
      end
    end

    // Flush a partial block, padded with Z.
    if (end_of_text && held_count > 0) begin
      for (int k = held_count; k < n; k++) held[k] = PadValue;
      encrypt_held_letters(n);
    end
  endtask

  always @(posedge clk) begin
    cipher_beat_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      block_size = 3'd2;
      key_row    = '{default: '0};
      held_count = 0;
      cipher_expected_q.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegBlockSize: block_size = size_t'(cfg_data);
          RegKeyRow0:   key_row[0] = cfg_data;
          RegKeyRow1:   key_row[1] = cfg_data;
          RegKeyRow2:   key_row[2] = cfg_data;
          RegKeyRow3:   key_row[3] = cfg_data;
          default: ;
        endcase
      end

      if (text_mon.valid && text_mon.ready)
        absorb_text(text_mon.text_byte, text_mon.end_of_text);

      if (cipher_mon.valid && cipher_mon.ready) begin
        if (cipher_expected_q.size() == 0) begin
          $error("cipher_letter: no beat expected, actual %0d", cipher_mon.cipher_letter);
          bad++;
        end else begin
          want = cipher_expected_q.pop_front();
          if (cipher_mon.cipher_letter !== want.cipher_letter) begin
            $error("cipher_letter: expected %0d, actual %0d",
                   want.cipher_letter, cipher_mon.cipher_letter);
            bad++;
          end
          if (cipher_mon.block_end !== want.block_end) begin
            $error("block_end: expected %0d, actual %0d",
                   want.block_end, cipher_mon.block_end);
            bad++;
          end
        end
      end
      mismatch_count <= mismatch_count + bad;
    end
    letters_pending <= cipher_expected_q.size();
  end

endmodule

[tb/hill_block_encrypt_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_block_encrypt_core_tb: stimulus and verdict for the Hill cipher core
// Drives text beats and key programming, stalls the cipher side at random and
// leaves prediction and comparison to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
module hill_block_encrypt_core_tb;
  import hbe_pkg::*;

  // Watchdog limit on the whole run, well above the slowest legal run.
  localparam int CycleLimit     = 400_000;
  localparam int RandomItems    = 90;
  localparam int LongHoldCycles = 400;
  // Covers a block's busy stretch plus the output register, with margin.
  localparam int DrainCycles    = 12;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int mismatch_count;
  int letters_pending;
  int cycle_count;
  int counted_items;      // letter or end-of-text beats, noise does not count
  int steady_beats_left;  // beats still to be sent back to back
  bit long_hold_req;      // ask the cipher sink for one long hold-off

  hbe_text_if   text_ch ();
  hbe_cipher_if cipher_ch ();

  hill_block_encrypt_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .text_in    (text_ch),
    .cipher_out (cipher_ch)
  );

  hill_cipher_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .text_mon        (text_ch),
    .cipher_mon      (cipher_ch),
    .mismatch_count  (mismatch_count),
    .letters_pending (letters_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake or a missing cipher letter ends here.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hill_block_encrypt_core_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Cipher sink: alternate ready runs with holds, mostly short, a few long.
  // A request from the stimulus forces one very long hold so the core backs
  // up into its text input.
  // --------------------------------------------------------------------------
  initial begin : cipher_sink
    int hold_left;
    int run_left;
    int pick;
    hold_left = 0;
    run_left  = 0;
    cipher_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCycles;
        run_left      = 0;
      end else if (hold_left == 0 && run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          hold_left = $urandom_range(20, 60);
        else if (pick < 55)
          hold_left = $urandom_range(1, 3);
        // Occasionally a long stretch with no stall at all.
        run_left = (pick >= 90) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      end
      if (hold_left > 0) begin
        cipher_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        cipher_ch.ready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Text source helpers
  // --------------------------------------------------------------------------

  // Idle cycles before the next text beat; zero inside a steady burst.
  function automatic int next_gap();
    int pick;
    if (steady_beats_left > 0) begin
      steady_beats_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) steady_beats_left = $urandom_range(8, 24);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit is_letter(input logic [7:0] text_byte);
    return (text_byte >= UpperFirst && text_byte <= UpperLast) ||
           (text_byte >= LowerFirst && text_byte <= LowerLast);
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? LowerFirst : UpperFirst;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [CfgDataW-1:0] random_key_row();
    return CfgDataW'($urandom_range(0, 20'hFFFFF));
  endfunction

  // Offer one text beat and hold it until the core takes it. Valid stays high
  // when the next beat follows with no gap.
  task automatic send_text(input logic [7:0] text_byte, input logic end_of_text);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= text_byte;
    text_ch.end_of_text <= end_of_text;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    if (end_of_text || is_letter(text_byte)) counted_items++;
  endtask

  // Drop valid, wait out every expected letter, then let the core go idle.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (letters_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Program all five registers back to back, then release the write enable.
  task automatic load_config(input int bs, input logic [CfgDataW-1:0] row0,
                             input logic [CfgDataW-1:0] row1,
                             input logic [CfgDataW-1:0] row2,
                             input logic [CfgDataW-1:0] row3);
    cfg_we    <= 1'b1;
    cfg_index <= RegBlockSize;
    cfg_data  <= CfgDataW'(bs);
    @(posedge clk);
    cfg_index <= RegKeyRow0;
    cfg_data  <= row0;
    @(posedge clk);
    cfg_index <= RegKeyRow1;
    cfg_data  <= row1;
    @(posedge clk);
    cfg_index <= RegKeyRow2;
    cfg_data  <= row2;
    @(posedge clk);
    cfg_index <= RegKeyRow3;
    cfg_data  <= row3;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_block_size(input int bs);
    cfg_we    <= 1'b1;
    cfg_index <= RegBlockSize;
    cfg_data  <= CfgDataW'(bs);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Text source: directed cases, then random messages under random keys.
  // --------------------------------------------------------------------------
  initial begin : text_source
    int bs;
    int length;
    int phase;
    int phase_end;

    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= RegBlockSize;
    cfg_data            <= '0;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= '0;
    text_ch.end_of_text <= 1'b0;
    long_hold_req       = 1'b0;
    steady_beats_left   = 0;
    counted_items       = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset key is all zero: every row sums to 0, which comes out as Z.
    send_text(UpperFirst, 1'b0);
    send_text(LowerLast, 1'b0);
    drain_results();

    // Widest block. Row 0 holds 31s (wrap to 5), row 2 the largest legal 25s,
    // row 3 mixes 26 (wraps to 0) with plain values.
    load_config(4, {4{5'd31}}, 20'h0, {4{5'd25}}, {5'd26, 5'd0, 5'd13, 5'd1});
    send_text(UpperFirst, 1'b0);
    send_text(UpperLast, 1'b0);
    send_text(LowerFirst, 1'b0);
    send_text(LowerLast, 1'b0);
    // Neighbors of the letter ranges and the byte extremes: all dropped.
    send_text(8'h40, 1'b0);
    send_text(8'h5B, 1'b0);
    send_text(8'h7B, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    // One letter then end of text: padded with three Z.
    send_text("m", 1'b1);
    // End of text with nothing held: no letters out.
    send_text(8'h2E, 1'b1);
    // The end-of-text letter completes the block: no second flush.
    send_text("Q", 1'b0);
    send_text("r", 1'b0);
    send_text("S", 1'b0);
    send_text("t", 1'b1);
    drain_results();

    // Size below range acts as two; a non-letter end of text still flushes.
    load_config(0, random_key_row(), random_key_row(), random_key_row(), random_key_row());
    send_text("h", 1'b0);
    send_text(8'h20, 1'b1);
    drain_results();

    // Size above range acts as four; two letters get two Z pads.
    load_config(7, random_key_row(), random_key_row(), random_key_row(), random_key_row());
    send_text("k", 1'b0);
    send_text("E", 1'b1);
    drain_results();

    // Shrink the block with three letters held: the next letter triggers the
    // first two and the rest are discarded.
    set_block_size(4);
    send_text("x", 1'b0);
    send_text("Y", 1'b0);
    send_text("w", 1'b0);
    drain_results();
    set_block_size(2);
    send_text("v", 1'b0);
    drain_results();

    // Same shrink, but flushed by a non-letter end of text.
    set_block_size(4);
    send_text("c", 1'b0);
    send_text("D", 1'b0);
    send_text("f", 1'b0);
    drain_results();
    set_block_size(2);
    send_text(8'h21, 1'b1);
    drain_results();

    // Random messages: mostly letters, some noise, usually closed by end of
    // text. A fresh key and size for every phase.
    counted_items = 0;
    phase         = 0;
    while (counted_items < RandomItems) begin
      bs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
      load_config(bs, random_key_row(), random_key_row(), random_key_row(),
                  random_key_row());

      if (phase == 2) begin
        // Hold the cipher side off while letters keep coming back to back,
        // so the core fills up and stalls the text input.
        long_hold_req     = 1'b1;
        steady_beats_left = 24;
        repeat (24) send_text(random_letter(), 1'b0);
      end

      phase_end = counted_items + 20;
      while (counted_items < phase_end) begin
        length = $urandom_range(0, 11);
        for (int i = 0; i < length; i++) begin
          if ($urandom_range(0, 9) == 0) send_text(random_byte(), 1'b0);
          send_text(random_letter(), 1'b0);
        end
        // Some messages run on into the next one without a flush.
        if ($urandom_range(0, 5) != 0)
          send_text(($urandom_range(0, 2) == 0) ? random_byte() : random_letter(), 1'b1);
      end

      // Pause the source until every cipher letter is back.
      drain_results();
      phase++;
    end

    if (mismatch_count == 0)
      $display("hill_block_encrypt_core_tb: done, clean");
    else
      $display("hill_block_encrypt_core_tb: done, errors");
    $finish;
  end

endmodule
